/* src/woi_pkg.sv */
// woi_pkg: types, constants and tables for the wheel odometry integrator
// no dependencies

package woi_pkg;

  localparam int unsigned PI_Q24 = 52707179;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [16:0] C_QUARTER = 17'd16384;
  localparam logic [16:0] C_YAW = 17'd68616;
  localparam logic [7:0] PADDR_WHEEL_SCALE = 8'h00;
  localparam logic [7:0] PADDR_STEP_TIME = 8'h04;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_HEAD,
    ST_WRAP,
    ST_CORDIC_PREP,
    ST_CORDIC,
    ST_ROT,
    ST_POS,
    ST_DONE
  } state_e;

  // arctangent table, Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 34'sd843314857;
      5'd1: atan_q30 = 34'sd497837829;
      5'd2: atan_q30 = 34'sd263043837;
      5'd3: atan_q30 = 34'sd133525159;
      5'd4: atan_q30 = 34'sd67021687;
      5'd5: atan_q30 = 34'sd33543516;
      5'd6: atan_q30 = 34'sd16775851;
      5'd7: atan_q30 = 34'sd8388437;
      5'd8: atan_q30 = 34'sd4194283;
      5'd9: atan_q30 = 34'sd2097149;
      5'd10: atan_q30 = 34'sd1048576;
      5'd11: atan_q30 = 34'sd524288;
      5'd12: atan_q30 = 34'sd262144;
      5'd13: atan_q30 = 34'sd131072;
      5'd14: atan_q30 = 34'sd65536;
      5'd15: atan_q30 = 34'sd32768;
      5'd16: atan_q30 = 34'sd16384;
      5'd17: atan_q30 = 34'sd8192;
      5'd18: atan_q30 = 34'sd4096;
      5'd19: atan_q30 = 34'sd2048;
      5'd20: atan_q30 = 34'sd1024;
      5'd21: atan_q30 = 34'sd512;
      5'd22: atan_q30 = 34'sd256;
      5'd23: atan_q30 = 34'sd128;
      default: atan_q30 = 34'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -80'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

endpackage

/* src/wheel_odometry_integrator.sv */
// wheel_odometry_integrator: top level, sequencer, shared multiplier, apb registers
// depends on woi_pkg and woi_cordic
//
// channel | direction | handshake
// in      | input     | in_valid_i / in_ready_o, eight wheel rates
// out     | output    | out_valid_o / out_ready_i, pose and velocities
// apb     | input     | psel/penable/pwrite, pready always high
//
// a taken word goes through nine multiplier steps for the velocities, the
// heading wrap, and two cordic passes on the single micro-rotation unit, and
// the products go one at a time through one shared 37 x 34 multiplier.
// reset clears the state to zero and the registers to their reset values.
// the block is not ready while a word is at work or its result waits.

module wheel_odometry_integrator #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] wheel_rate_0_i,
  input  logic signed [15:0] wheel_rate_1_i,
  input  logic signed [15:0] wheel_rate_2_i,
  input  logic signed [15:0] wheel_rate_3_i,
  input  logic signed [15:0] wheel_rate_4_i,
  input  logic signed [15:0] wheel_rate_5_i,
  input  logic signed [15:0] wheel_rate_6_i,
  input  logic signed [15:0] wheel_rate_7_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic signed [31:0] yaw_rate_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PSH = 24 - FRAC_BITS;
  localparam logic signed [33:0] PQ = (PSH == 0) ? 34'(woi_pkg::PI_Q24) :
      34'((woi_pkg::PI_Q24 + (1 << (PSH - 1))) >> PSH);
  localparam logic signed [33:0] TP = PQ * 2;
  localparam logic signed [35:0] TPW = 36'(TP);
  localparam int WK = 31 - FRAC_BITS;
  localparam int SH = 48 - FRAC_BITS;

  woi_pkg::state_e state_q, state_d;

  logic [31:0] ws_q;
  logic [23:0] st_q;
  logic signed [31:0] lx_q, ly_q, lh_q, lvx_q, lvy_q, lw_q;
  logic signed [31:0] vx_q, vy_q, w_q, hd_q, px_q, py_q;
  logic signed [19:0] se_q, so_q, mix_q;
  logic signed [35:0] th_q;
  logic signed [33:0] c1_q, s1_q;
  logic signed [33:0] acc_x_q, acc_y_q;
  logic signed [79:0] tmp_q, lo_q;
  logic [4:0] cnt_q;
  logic cpass_q;

  // shared multiplier operands and product
  logic signed [36:0] ma;
  logic signed [33:0] mb;
  logic signed [70:0] prod;
  assign prod = ma * mb;

  // register file
  assign pready = 1'b1;
  always_comb begin
    case ({5'd0, paddr})
      woi_pkg::PADDR_WHEEL_SCALE: prdata = ws_q;
      woi_pkg::PADDR_STEP_TIME: prdata = {8'd0, st_q};
      default: prdata = '0;
    endcase
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= 32'd1464; st_q <= 24'd16777;
    end else if (psel && penable && pwrite) begin
      case ({5'd0, paddr})
        woi_pkg::PADDR_WHEEL_SCALE: ws_q <= pwdata;
        woi_pkg::PADDR_STEP_TIME: st_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // cordic, shared by both heading passes
  logic cstart, cdone;
  logic signed [33:0] ccos, csin;
  woi_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cstart), .angle_i(cpass_q ? lh_q : hd_q),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin)
  );

  assign in_ready_o  = (state_q == woi_pkg::ST_IDLE);
  assign out_valid_o = (state_q == woi_pkg::ST_DONE);
  assign pos_x_o = px_q; assign pos_y_o = py_q; assign heading_o = hd_q;
  assign vel_x_o = vx_q; assign vel_y_o = vy_q; assign yaw_rate_o = w_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      woi_pkg::ST_IDLE: if (in_valid_i) state_d = woi_pkg::ST_SCALE;
      woi_pkg::ST_SCALE: if (cnt_q == 5'd8) state_d = woi_pkg::ST_HEAD;
      woi_pkg::ST_HEAD: state_d = woi_pkg::ST_WRAP;
      woi_pkg::ST_WRAP: if (cnt_q == 5'(WK + 3)) state_d = woi_pkg::ST_CORDIC_PREP;
      woi_pkg::ST_CORDIC_PREP: state_d = woi_pkg::ST_CORDIC;
      woi_pkg::ST_CORDIC: if (cdone) state_d = woi_pkg::ST_ROT;
      woi_pkg::ST_ROT:
        if (cnt_q == 5'd3) state_d = cpass_q ? woi_pkg::ST_POS : woi_pkg::ST_CORDIC_PREP;
      woi_pkg::ST_POS: if (cnt_q == 5'd1) state_d = woi_pkg::ST_DONE;
      woi_pkg::ST_DONE: if (out_ready_i) state_d = woi_pkg::ST_IDLE;
      default: state_d = woi_pkg::ST_IDLE;
    endcase
  end

  // multiplier operand select
  always_comb begin
    ma = '0; mb = '0;
    case (state_q)
      woi_pkg::ST_SCALE: begin
        // sum times constant, then that times each half of wheel_scale
        case (cnt_q)
          5'd0: begin
            ma = 37'(se_q); mb = 34'(woi_pkg::C_QUARTER);
          end
          5'd3: begin
            ma = 37'(so_q); mb = 34'(woi_pkg::C_QUARTER);
          end
          5'd6: begin
            ma = 37'(mix_q); mb = 34'(woi_pkg::C_YAW);
          end
          5'd1, 5'd4, 5'd7: begin
            ma = 37'(tmp_q); mb = 34'({1'b0, ws_q[15:0]});
          end
          default: begin
            ma = 37'(tmp_q); mb = 34'({1'b0, ws_q[31:16]});
          end
        endcase
      end
      woi_pkg::ST_HEAD: begin
        ma = 37'(lw_q) + 37'(w_q); mb = 34'({1'b0, st_q});
      end
      woi_pkg::ST_ROT: begin
        ma = (cnt_q[1] ^ cnt_q[0]) ? 37'(cpass_q ? lvy_q : vy_q) :
                                     37'(cpass_q ? lvx_q : vx_q);
        mb = cnt_q[0] ? s1_q : c1_q;
      end
      woi_pkg::ST_POS: begin
        ma = cnt_q[0] ? 37'(acc_y_q) : 37'(acc_x_q); mb = 34'({1'b0, st_q});
      end
      default: ;
    endcase
  end

  assign cstart = (state_q == woi_pkg::ST_CORDIC_PREP);

  // datapath
  logic signed [79:0] vsc;
  logic signed [33:0] rot;
  logic [4:0] wsh;
  logic signed [35:0] tpk;
  always_comb begin
    vsc = (80'(prod) + (lo_q >>> 16)) >>> (SH - 16);
    rot = 34'((lo_q + prod) >>> 30);
    wsh = 5'(WK + 2) - cnt_q;
    tpk = TPW <<< wsh;
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      woi_pkg::ST_IDLE: if (in_valid_i) begin
        se_q <= 20'(wheel_rate_0_i) + 20'(wheel_rate_2_i) + 20'(wheel_rate_4_i)
                + 20'(wheel_rate_6_i);
        so_q <= 20'(wheel_rate_1_i) + 20'(wheel_rate_3_i) + 20'(wheel_rate_5_i)
                + 20'(wheel_rate_7_i);
        mix_q <= 20'(wheel_rate_0_i) - 20'(wheel_rate_1_i) + 20'(wheel_rate_2_i)
                 + 20'(wheel_rate_3_i) - 20'(wheel_rate_4_i) + 20'(wheel_rate_5_i)
                 - 20'(wheel_rate_6_i) + 20'(wheel_rate_7_i);
      end
      woi_pkg::ST_SCALE: begin
        case (cnt_q)
          5'd0, 5'd3, 5'd6: tmp_q <= 80'(prod);
          5'd1, 5'd4, 5'd7: lo_q <= 80'(prod);
          5'd2: vx_q <= woi_pkg::sat32(vsc);
          5'd5: vy_q <= woi_pkg::sat32(vsc);
          default: w_q <= woi_pkg::sat32(vsc);
        endcase
      end
      woi_pkg::ST_HEAD: th_q <= 36'(lh_q) + 36'(prod >>> 25);
      woi_pkg::ST_WRAP: begin
        // reduce modulo two pi by shifted compare and subtract
        if (cnt_q == 5'd0) th_q <= th_q + 36'(PQ);
        else if (cnt_q == 5'd1) begin
          if (th_q < 0) th_q <= th_q + (TPW <<< WK);
        end else if (cnt_q == 5'(WK + 3)) hd_q <= 32'(th_q - 36'(PQ));
        else if (th_q >= tpk) th_q <= th_q - tpk;
      end
      woi_pkg::ST_CORDIC: if (cdone) begin
        c1_q <= ccos; s1_q <= csin;
      end
      woi_pkg::ST_ROT: begin
        case (cnt_q[1:0])
          2'd0: lo_q <= 80'(prod);
          2'd1: begin
            if (cpass_q) acc_x_q <= acc_x_q + rot;
            else acc_x_q <= rot;
            lo_q <= '0;
          end
          2'd2: lo_q <= 80'(prod);
          default: begin
            if (cpass_q) acc_y_q <= acc_y_q + 34'((lo_q - prod) >>> 30);
            else acc_y_q <= 34'((lo_q - prod) >>> 30);
          end
        endcase
      end
      woi_pkg::ST_POS: begin
        if (cnt_q[0]) py_q <= woi_pkg::sat32(80'(ly_q) + (prod >>> 25));
        else px_q <= woi_pkg::sat32(80'(lx_q) + (prod >>> 25));
      end
      default: ;
    endcase
  end

  // sequencing counters, state and held pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= woi_pkg::ST_IDLE; cnt_q <= '0; cpass_q <= 1'b0;
      lx_q <= '0; ly_q <= '0; lh_q <= '0; lvx_q <= '0; lvy_q <= '0; lw_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) cnt_q <= '0;
      else cnt_q <= cnt_q + 5'd1;
      if (state_q == woi_pkg::ST_IDLE) cpass_q <= 1'b0;
      else if (state_q == woi_pkg::ST_ROT && state_d == woi_pkg::ST_CORDIC_PREP)
        cpass_q <= 1'b1;
      if (state_q == woi_pkg::ST_DONE && out_ready_i) begin
        lx_q <= px_q; ly_q <= py_q; lh_q <= hd_q;
        lvx_q <= vx_q; lvy_q <= vy_q; lw_q <= w_q;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_in_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (34'(heading_o) >= -PQ && 34'(heading_o) < PQ))
    else $error("heading outside wrap range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o))
    else $error("result dropped while stalled");
`endif

endmodule

/* src/woi_cordic.sv */
// woi_cordic: iterative rotation cordic, one micro-rotation per cycle
// depends on woi_pkg

module woi_cordic #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int NSTEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam logic signed [35:0] PI30 = 36'(woi_pkg::PI_Q24) * 36'sd64;
  localparam logic signed [35:0] HALF = PI30 / 2;

  logic signed [33:0] x_q, y_q, x_d, y_d;
  logic signed [35:0] z_q, z_d, z0;
  logic [4:0] i_q, i_d;
  logic busy_q, busy_d, flip_q, flip_d, done_q, done_d;

  // sign-corrected results
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;
  assign done_o = done_q;

  // next state of the rotation
  always_comb begin
    z0 = 36'(angle_i) <<< (30 - FRAC_BITS);
    x_d = x_q; y_d = y_q; z_d = z_q; i_d = i_q;
    busy_d = busy_q; flip_d = flip_q; done_d = 1'b0;
    if (start_i) begin
      x_d = woi_pkg::CORDIC_GAIN; y_d = '0; i_d = '0; busy_d = 1'b1;
      flip_d = 1'b0; z_d = z0;
      if (z0 > HALF) begin
        z_d = z0 - PI30; flip_d = 1'b1;
      end else if (z0 < -HALF) begin
        z_d = z0 + PI30; flip_d = 1'b1;
      end
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - (y_q >>> i_q);
        y_d = y_q + (x_q >>> i_q);
        z_d = z_q - 36'(woi_pkg::atan_q30(i_q));
      end else begin
        x_d = x_q + (y_q >>> i_q);
        y_d = y_q - (x_q >>> i_q);
        z_d = z_q + 36'(woi_pkg::atan_q30(i_q));
      end
      i_d = i_q + 5'd1;
      if (i_q == 5'(NSTEPS - 1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; i_q <= '0; flip_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; i_q <= i_d; flip_q <= flip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
  end

endmodule
